### design/apf_pkg.sv
// Package: types and constants of the articulation point finder.
`default_nettype none
package apf_pkg;
  localparam int unsigned NumVertices = 64;
  localparam int unsigned NumEdges    = 256;
  localparam int unsigned VertW       = 6;
  localparam int unsigned EdgeIdxW    = 8;
  localparam int unsigned EdgeCntW    = 9;
  localparam int unsigned TimeW       = 7;
  localparam int unsigned SpW         = 7;
  localparam int unsigned StkW        = VertW + EdgeCntW;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_COMPUTE = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VertW-1:0] vertex_a;
    logic [VertW-1:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic [VertW-1:0] point_vertex;
    logic             none_found;
    logic             edge_overflow;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_OUTER,
    ST_WAIT,
    ST_SCAN,
    ST_BACK,
    ST_POP,
    ST_FETCH,
    ST_JOIN,
    ST_EMIT,
    ST_HOLD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_edge;
    logic clear_graph;
    logic init_run;
    logic outer_next;
    logic start_root;
    logic scan_step;
    logic edge_step;
    logic back_step;
    logic root_done;
    logic pop_fetch;
    logic pop_join;
    logic emit_scan;
    logic emit_take;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic outer_done;
    logic outer_start;
    logic stack_last;
    logic scan_end;
    logic scan_hit;
    logic back_edge;
    logic emit_done;
    logic emit_found;
  } stat_t;
endpackage
`default_nettype wire

### design/apf_ram.sv
// Generic single-port-write, one-read RAM with registered read.
`default_nettype none
module apf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### design/apf_datapath.sv
// Datapath: edge store, per-vertex tables, search stack and result scan.
`default_nettype none
module apf_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire apf_pkg::in_item_t in_i,
  input  wire apf_pkg::cmd_t     cmd_i,
  output apf_pkg::stat_t         stat_o,
  output apf_pkg::out_item_t     res_o
);
  import apf_pkg::*;

  logic [EdgeCntW-1:0]    edge_count_q;
  logic                   overflow_q;
  logic [NumVertices-1:0] present_q, visited_q, cut_q;
  logic [SpW-1:0]         sp_q;
  logic [TimeW-1:0]       time_q;
  logic [VertW:0]         vptr_q;
  logic [VertW-1:0]       root_q;
  logic                   root_any_q, root_gt1_q;
  // Top stack frame, held in registers.
  logic [VertW-1:0]       u_q;
  logic [EdgeCntW-1:0]    i_q;
  logic [TimeW-1:0]       ulow_q;
  logic [VertW-1:0]       upar_q;
  logic [VertW:0]         eptr_q;
  logic                   found_q;

  logic [2*VertW-1:0]  edge_rd;
  logic                add_ok;
  logic [VertW-1:0]    ea, eb, w;
  logic                push_ok;
  logic [TimeW-1:0]    new_time;
  logic [StkW-1:0]     stk_rd;
  logic [VertW-1:0]    stk_waddr, stk_raddr;
  logic [VertW-1:0]    pop_v;
  logic [EdgeCntW-1:0] pop_i;
  logic                disc_we;
  logic [VertW-1:0]    disc_waddr, disc_raddr;
  logic [TimeW-1:0]    disc_rd, low_rd;
  logic [VertW-1:0]    par_rd;

  assign add_ok = cmd_i.add_edge && (edge_count_q < EdgeCntW'(NumEdges));

  apf_ram #(.Width(2*VertW), .Depth(NumEdges)) u_edges (
    .clk_i   (clk_i),
    .we_i    (add_ok),
    .waddr_i (edge_count_q[EdgeIdxW-1:0]),
    .wdata_i ({in_i.vertex_a, in_i.vertex_b}),
    .raddr_i (i_q[EdgeIdxW-1:0]),
    .rdata_o (edge_rd)
  );

  assign ea       = edge_rd[2*VertW-1:VertW];
  assign eb       = edge_rd[VertW-1:0];
  assign w        = (ea == u_q) ? eb : ea;
  assign new_time = time_q + TimeW'(1);
  assign push_ok  = cmd_i.edge_step && !visited_q[w] && (sp_q < SpW'(NumVertices));

  // Frames below the top: vertex and resume position.
  assign stk_waddr = sp_q[VertW-1:0] - VertW'(1);
  assign stk_raddr = sp_q[VertW-1:0] - VertW'(2);
  assign pop_v     = stk_rd[StkW-1:EdgeCntW];
  assign pop_i     = stk_rd[EdgeCntW-1:0];

  apf_ram #(.Width(StkW), .Depth(NumVertices)) u_stack (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (stk_waddr),
    .wdata_i ({u_q, i_q + EdgeCntW'(1)}),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  assign disc_we    = cmd_i.start_root || push_ok;
  assign disc_waddr = cmd_i.start_root ? vptr_q[VertW-1:0] : w;
  assign disc_raddr = cmd_i.pop_fetch ? pop_v : w;

  apf_ram #(.Width(TimeW), .Depth(NumVertices)) u_disc (
    .clk_i   (clk_i),
    .we_i    (disc_we),
    .waddr_i (disc_waddr),
    .wdata_i (new_time),
    .raddr_i (disc_raddr),
    .rdata_o (disc_rd)
  );

  apf_ram #(.Width(TimeW), .Depth(NumVertices)) u_low (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (u_q),
    .wdata_i (ulow_q),
    .raddr_i (pop_v),
    .rdata_o (low_rd)
  );

  apf_ram #(.Width(VertW), .Depth(NumVertices)) u_parent (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (w),
    .wdata_i (u_q),
    .raddr_i (pop_v),
    .rdata_o (par_rd)
  );

  assign stat_o.outer_done  = vptr_q[VertW];
  assign stat_o.outer_start = !vptr_q[VertW] && present_q[vptr_q[VertW-1:0]]
                              && !visited_q[vptr_q[VertW-1:0]];
  assign stat_o.stack_last  = (sp_q == SpW'(1));
  assign stat_o.scan_end    = (i_q >= edge_count_q);
  assign stat_o.scan_hit    = (ea == u_q) || (eb == u_q);
  // The root has no parent, so every visited neighbor of it is a back edge.
  assign stat_o.back_edge   = visited_q[w] && ((u_q == root_q) || (w != upar_q));
  assign stat_o.emit_done   = eptr_q[VertW];
  assign stat_o.emit_found  = !eptr_q[VertW] && cut_q[eptr_q[VertW-1:0]];

  assign res_o.point_vertex  = found_q ? eptr_q[VertW-1:0] : '0;
  assign res_o.none_found    = !found_q;
  assign res_o.edge_overflow = overflow_q;
  assign res_o.last          = !found_q || (cut_q >> (eptr_q[VertW-1:0] + VertW'(1)) == '0)
                               || (eptr_q[VertW-1:0] == VertW'(NumVertices-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= '0;
      overflow_q   <= 1'b0;
      present_q    <= '0;
      visited_q    <= '0;
      cut_q        <= '0;
      sp_q         <= '0;
      time_q       <= '0;
      vptr_q       <= '0;
      root_q       <= '0;
      root_any_q   <= 1'b0;
      root_gt1_q   <= 1'b0;
      u_q          <= '0;
      i_q          <= '0;
      ulow_q       <= '0;
      upar_q       <= '0;
      eptr_q       <= '0;
      found_q      <= 1'b0;
    end else begin
      if (cmd_i.add_edge) begin
        if (add_ok) begin
          edge_count_q <= edge_count_q + EdgeCntW'(1);
          present_q    <= present_q | (NumVertices'(1) << in_i.vertex_a)
                                    | (NumVertices'(1) << in_i.vertex_b);
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (cmd_i.clear_graph) begin
        edge_count_q <= '0;
        overflow_q   <= 1'b0;
        present_q    <= '0;
        visited_q    <= '0;
        cut_q        <= '0;
        time_q       <= '0;
      end
      if (cmd_i.init_run) begin
        visited_q <= '0;
        cut_q     <= '0;
        time_q    <= '0;
        vptr_q    <= '0;
        eptr_q    <= '0;
        found_q   <= 1'b0;
      end
      if (cmd_i.outer_next) begin
        vptr_q <= vptr_q + (VertW+1)'(1);
      end
      if (cmd_i.start_root) begin
        visited_q[vptr_q[VertW-1:0]] <= 1'b1;
        time_q     <= new_time;
        root_q     <= vptr_q[VertW-1:0];
        root_any_q <= 1'b0;
        root_gt1_q <= 1'b0;
        u_q        <= vptr_q[VertW-1:0];
        i_q        <= '0;
        ulow_q     <= new_time;
        upar_q     <= vptr_q[VertW-1:0];
        sp_q       <= SpW'(1);
      end
      if (cmd_i.scan_step) begin
        i_q <= i_q + EdgeCntW'(1);
      end
      if (cmd_i.edge_step) begin
        if (push_ok) begin
          // Save the current frame below and make the new vertex the top.
          if (u_q == root_q) begin
            root_gt1_q <= root_any_q;
            root_any_q <= 1'b1;
          end
          visited_q[w] <= 1'b1;
          time_q <= new_time;
          u_q    <= w;
          i_q    <= '0;
          ulow_q <= new_time;
          upar_q <= u_q;
          sp_q   <= sp_q + SpW'(1);
        end else begin
          i_q <= i_q + EdgeCntW'(1);
        end
      end
      if (cmd_i.back_step) begin
        if (disc_rd < ulow_q) begin
          ulow_q <= disc_rd;
        end
      end
      if (cmd_i.root_done) begin
        if (root_gt1_q) begin
          cut_q[root_q] <= 1'b1;
        end
        sp_q <= '0;
      end
      if (cmd_i.pop_join) begin
        // Merge the finished child into its parent, which becomes the top.
        if (low_rd < ulow_q) begin
          ulow_q <= low_rd;
        end
        if (pop_v != root_q && ulow_q >= disc_rd) begin
          cut_q[pop_v] <= 1'b1;
        end
        u_q    <= pop_v;
        i_q    <= pop_i;
        upar_q <= par_rd;
        sp_q   <= sp_q - SpW'(1);
      end
      if (cmd_i.emit_scan) begin
        eptr_q <= eptr_q + (VertW+1)'(1);
      end
      if (cmd_i.emit_take) begin
        found_q <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### design/apf_ctrl.sv
// Controller: sequences edge loading, depth-first search and result output.
`default_nettype none
module apf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire apf_pkg::in_item_t in_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire logic              res_last_i,
  input  wire apf_pkg::stat_t    stat_i,
  output apf_pkg::cmd_t          cmd_o
);
  import apf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (kind_e'(in_i.kind))
            KIND_ADD:     cmd_o.add_edge = 1'b1;
            KIND_CLEAR:   cmd_o.clear_graph = 1'b1;
            KIND_COMPUTE: state_d = ST_INIT;
            default:      ;
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.init_run = 1'b1;
        state_d = ST_OUTER;
      end
      ST_OUTER: begin
        if (stat_i.outer_done) begin
          state_d = ST_EMIT;
        end else if (stat_i.outer_start) begin
          cmd_o.start_root = 1'b1;
          state_d = ST_WAIT;
        end else begin
          cmd_o.outer_next = 1'b1;
        end
      end
      ST_WAIT: begin
        // Wait after a scan position change for the registered store read.
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = ST_POP;
        end else if (stat_i.scan_hit) begin
          cmd_o.edge_step = 1'b1;
          state_d = stat_i.back_edge ? ST_BACK : ST_WAIT;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = ST_WAIT;
        end
      end
      ST_BACK: begin
        cmd_o.back_step = 1'b1;
        state_d = ST_SCAN;
      end
      ST_POP: begin
        if (stat_i.stack_last) begin
          cmd_o.root_done  = 1'b1;
          cmd_o.outer_next = 1'b1;
          state_d = ST_OUTER;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.pop_fetch = 1'b1;
        state_d = ST_JOIN;
      end
      ST_JOIN: begin
        cmd_o.pop_join = 1'b1;
        state_d = ST_WAIT;
      end
      ST_EMIT: begin
        if (stat_i.emit_done) begin
          state_d = ST_HOLD;
        end else if (stat_i.emit_found) begin
          cmd_o.emit_take = 1'b1;
          state_d = ST_HOLD;
        end else begin
          cmd_o.emit_scan = 1'b1;
        end
      end
      ST_HOLD: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (res_last_i) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.emit_scan = 1'b1;
            state_d = ST_EMIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### design/articulation_point_finder_unit.sv
// Top level of the articulation point finder.
// Add-edge and clear items can follow back to back.
// A compute item stalls the input from its acceptance until the run's last
// result is taken. The run first clears its marks, then walks the vertices
// in ascending order, starting a search at each present unvisited one.
// Each search keeps the top stack frame in registers; every visited vertex
// scans the whole edge store once over its lifetime, each stored edge with
// a registered store read, then a decision; a back edge adds a low-time
// update, and a pop runs stack read, table read, merge and store read.
// Results leave in ascending vertex order, the last one marked, each held in
// place while stalled; an empty result set yields one item with none_found.
`default_nettype none
module articulation_point_finder_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire apf_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output apf_pkg::out_item_t      out_data_o
);
  import apf_pkg::*;

  cmd_t cmd;
  stat_t stat;

  apf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_last_i  (out_data_o.last),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  apf_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_data_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (out_data_o)
  );
endmodule
`default_nettype wire

### tb/tb_articulation_point_finder_unit.sv
// Testbench: random and directed graph checks of the articulation point finder.
`timescale 1ns / 100ps
`default_nettype none
module tb_articulation_point_finder_unit;
  import apf_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned LongHold = 600;
  localparam int          NoParent = -1;

  // One item in the send queue; typed rows carry their result written by hand.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t typed_res;
  } stim_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  articulation_point_finder_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  stim_t     send_q[$];
  stim_t     drv_item;
  out_item_t expected_points_q[$];
  int        error_count = 0;
  int        items_taken = 0;
  int        compute_runs = 0;
  int        results_checked = 0;
  int        cycle_count = 0;

  // Graph shadow: the testbench's own copy of the block's state.
  int        edge_end_a[NumEdges];
  int        edge_end_b[NumEdges];
  int        edge_total;
  bit        present[NumVertices];
  bit        visited[NumVertices];
  int        disc_time[NumVertices];
  int        low_time[NumVertices];
  int        parent_of[NumVertices];
  bit        is_cut[NumVertices];
  int        stack_v[NumVertices];
  int        stack_pos[NumVertices];
  int        kids[NumVertices];
  int        clock_tick;
  bit        dropped_edge;

  function automatic void graph_clear();
    edge_total = 0;
    dropped_edge = 1'b0;
    clock_tick = 0;
    for (int v = 0; v < NumVertices; v++) begin
      present[v] = 1'b0;
      visited[v] = 1'b0;
      is_cut[v] = 1'b0;
    end
  endfunction

  function automatic void mark_visit(int v, int par);
    visited[v] = 1'b1;
    clock_tick++;
    disc_time[v] = clock_tick;
    low_time[v] = clock_tick;
    parent_of[v] = par;
    kids[v] = 0;
  endfunction

  // Iterative depth-first search from one root, updating low times and cut marks.
  function automatic void search_tree(int root);
    int sp;
    int u;
    int i;
    int w;
    int p;
    mark_visit(root, NoParent);
    stack_v[0] = root;
    stack_pos[0] = 0;
    sp = 1;
    while (sp > 0) begin
      u = stack_v[sp-1];
      i = stack_pos[sp-1];
      while (i < edge_total && edge_end_a[i] != u && edge_end_b[i] != u) i++;
      if (i >= edge_total) begin
        sp--;
        if (sp > 0) begin
          p = stack_v[sp-1];
          if (low_time[u] < low_time[p]) low_time[p] = low_time[u];
          if (parent_of[p] != NoParent && low_time[u] >= disc_time[p]) is_cut[p] = 1'b1;
        end
      end else begin
        stack_pos[sp-1] = i + 1;
        w = (edge_end_a[i] == u) ? edge_end_b[i] : edge_end_a[i];
        if (!visited[w]) begin
          if (sp < NumVertices) begin
            kids[u]++;
            mark_visit(w, u);
            stack_v[sp] = w;
            stack_pos[sp] = 0;
            sp++;
          end
        end else if (w != parent_of[u]) begin
          if (disc_time[w] < low_time[u]) low_time[u] = disc_time[w];
        end
      end
    end
    if (kids[root] > 1) is_cut[root] = 1'b1;
  endfunction

  // Apply one accepted item to the shadow graph and return the cut points it yields.
  function automatic void predict_points(in_item_t it, ref out_item_t res[$]);
    out_item_t r;
    res.delete();
    case (kind_e'(it.kind))
      KIND_ADD: begin
        if (edge_total >= NumEdges) begin
          dropped_edge = 1'b1;
        end else begin
          edge_end_a[edge_total] = int'(it.vertex_a);
          edge_end_b[edge_total] = int'(it.vertex_b);
          edge_total++;
          present[it.vertex_a] = 1'b1;
          present[it.vertex_b] = 1'b1;
        end
      end
      KIND_CLEAR: graph_clear();
      KIND_COMPUTE: begin
        for (int v = 0; v < NumVertices; v++) begin
          visited[v] = 1'b0;
          is_cut[v] = 1'b0;
        end
        clock_tick = 0;
        for (int v = 0; v < NumVertices; v++)
          if (present[v] && !visited[v]) search_tree(v);
        for (int v = 0; v < NumVertices; v++) begin
          if (is_cut[v]) begin
            r.point_vertex = VertW'(v);
            r.none_found = 1'b0;
            r.edge_overflow = dropped_edge;
            r.last = 1'b0;
            res = {res, r};
          end
        end
        if (res.size() == 0) begin
          r = '0;
          r.none_found = 1'b1;
          r.edge_overflow = dropped_edge;
          r.last = 1'b1;
          res = {res, r};
        end else begin
          res[res.size()-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH %s", what);
    error_count++;
  endtask

  task automatic check_field(string field, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                results_checked, field, got, want));
  endtask

  function automatic stim_t mk(kind_e k, int a, int b);
    stim_t s;
    s.item.kind = k;
    s.item.vertex_a = VertW'(a);
    s.item.vertex_b = VertW'(b);
    s.typed = 1'b0;
    s.typed_res = '0;
    return s;
  endfunction

  function automatic stim_t mk_typed(int a, bit none, bit ovf);
    stim_t s;
    s = mk(KIND_COMPUTE, 0, 0);
    s.typed = 1'b1;
    s.typed_res.point_vertex = VertW'(a);
    s.typed_res.none_found = none;
    s.typed_res.edge_overflow = ovf;
    s.typed_res.last = 1'b1;
    return s;
  endfunction

  // Build the directed table, then the store-full sweep, then random graphs.
  initial begin : build_stimulus
    stim_t table_rows[$];
    int    n_edges;
    int    base;
    int    span;
    int    pick;
    graph_clear();
    table_rows = '{
      mk_typed(0, 1'b1, 1'b0),          // empty graph after reset
      mk(KIND_ADD, 0, 1), mk(KIND_ADD, 1, 2),
      mk_typed(1, 1'b0, 1'b0),          // path: middle vertex cuts
      mk(KIND_ADD, 63, 63),             // self loop only marks presence
      mk(KIND_ADD, 2, 1),               // parallel edge
      mk_typed(1, 1'b0, 1'b0),
      mk(KIND_UNUSED, 63, 63),          // ignored kind
      mk_typed(1, 1'b0, 1'b0),
      mk(KIND_CLEAR, 63, 0),
      mk_typed(0, 1'b1, 1'b0),
      mk(KIND_ADD, 0, 63), mk(KIND_ADD, 63, 62),
      mk_typed(63, 1'b0, 1'b0),
      mk(KIND_ADD, 62, 21), mk(KIND_ADD, 21, 42), mk(KIND_ADD, 42, 62),
      mk(KIND_ADD, 42, 5),
      mk(KIND_COMPUTE, 0, 0),           // several points, predicted
      mk(KIND_CLEAR, 0, 0)
    };
    send_q = {send_q, table_rows};
    // Fill the edge store past capacity with a long chain, then search it.
    for (int i = 0; i < NumEdges + 3; i++)
      send_q = {send_q, mk(KIND_ADD, i % NumVertices,
                           (i + 1 + i / NumVertices) % NumVertices)};
    send_q = {send_q, mk(KIND_COMPUTE, 0, 0)};
    send_q = {send_q, mk(KIND_CLEAR, 0, 0)};
    // Random graphs: mostly clear, a few edges in a window, compute.
    while (send_q.size() < 400) begin
      if ($urandom_range(0, 4) != 0) send_q = {send_q, mk(KIND_CLEAR, $urandom, $urandom)};
      n_edges = $urandom_range(1, 12);
      span = $urandom_range(2, 14);
      base = $urandom_range(0, NumVertices - span);
      for (int e = 0; e < n_edges; e++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_q = {send_q, mk(KIND_UNUSED, $urandom, $urandom)};
        else if (pick == 1) send_q = {send_q, mk(KIND_ADD, $urandom, $urandom)};
        else send_q = {send_q, mk(KIND_ADD, base + $urandom_range(0, span - 1),
                                  base + $urandom_range(0, span - 1))};
      end
      send_q = {send_q, mk(KIND_COMPUTE, $urandom, $urandom)};
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin : send_items
    stim_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (send_q.size() > 0) begin
        nxt = send_q.pop_front();
        drv_item <= nxt;
        in_data_i <= nxt.item;
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Input monitor: predict on every accepted item.
  always @(posedge clk_i) begin : take_input
    out_item_t res[$];
    if (rst_ni && in_valid_i && !in_stall_o) begin
      items_taken++;
      predict_points(in_data_i, res);
      if (kind_e'(in_data_i.kind) == KIND_COMPUTE) begin
        compute_runs++;
        if (drv_item.typed) expected_points_q = {expected_points_q, drv_item.typed_res};
        else expected_points_q = {expected_points_q, res};
      end
    end
  end

  // Receiver: the stall pattern switches at random among three modes; one long hold-off.
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  stall_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!hold_done && results_checked >= 6) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (cycle_count % 32 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_mode == 0) begin
        out_stall_i <= 1'b0;
      end else if (stall_mode == 1) begin
        out_stall_i <= ($urandom_range(0, 1) == 0);
      end else begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Output monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_output
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, vertex %0d",
                                  out_data_o.point_vertex));
      end else begin
        want = expected_points_q.pop_front();
        check_field("point_vertex", int'(out_data_o.point_vertex),
                    int'(want.point_vertex));
        check_field("none_found", int'(out_data_o.none_found), int'(want.none_found));
        check_field("edge_overflow", int'(out_data_o.edge_overflow),
                    int'(want.edge_overflow));
        check_field("last", int'(out_data_o.last), int'(want.last));
      end
      results_checked++;
    end
  end

  // Watchdog: end the run if it never drains.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : run_control
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Drain sender, then results, then a short quiet stretch.
    while (send_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_points_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_points_q.size() > 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_points_q.size()));
    end
    $display("covered %0d items, %0d compute runs, %0d results checked",
             items_taken, compute_runs, results_checked);
    $display("including a store overflow sweep and a long output hold-off");
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
design/apf_pkg.sv
design/apf_ram.sv
design/apf_datapath.sv
design/apf_ctrl.sv
design/articulation_point_finder_unit.sv
tb/tb_articulation_point_finder_unit.sv
